FILE: sv/rdt_pkg.sv
package rdt_pkg;

   // request kinds
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   // result status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_LOOKUP,
      ST_DRAIN,
      ST_FINISH
   } rdt_state_type;

   // one stored table entry
   typedef struct packed {
      logic [31:0] source;
      logic [31:0] number;
      logic [63:0] expiry;
   } rdt_entry_type;

endpackage

FILE: sv/request_dedup_table_with_expiry.sv
// Sequence: an insert steps through the slots from slot 0 and writes the first free one, ending
// at the last slot when the table is full; a lookup reads every slot, then drains, before its response.
// Throughput: one transaction at a time; a new request is taken the cycle after the response
// is loaded, and the lookup scan is paced by the entry RAM's single read port
// reading one slot per cycle.
// Reset: synchronous; slot used bits clear at once (no clearing pass), entry RAM is not reset.
module request_dedup_table_with_expiry #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_broadcast_number,
   input  logic [63:0] req_expiry_time,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_status
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EW = $bits(rdt_pkg::rdt_entry_type);

   rdt_pkg::rdt_state_type state_ff, state_in;

   logic [TABLE_DEPTH-1:0] used_ff, used_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   eval_valid_ff, eval_valid_in;
   logic [IW-1:0]          eval_idx_ff;
   logic                   hit_ff, hit_in;
   logic                   status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_status_ff;

   // captured request
   logic        kind_ff;
   logic [31:0] source_ff;
   logic [31:0] number_ff;
   logic [63:0] expiry_ff;
   logic [63:0] now_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  last_idx;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   rdt_pkg::rdt_entry_type wr_entry;
   rdt_pkg::rdt_entry_type rd_entry;
   logic [EW-1:0]         rd_bits;

   assign req_stall  = (state_ff != rdt_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign last_idx   = (idx_ff == IW'(TABLE_DEPTH - 1));
   assign rsp_load   = (state_ff == rdt_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // entry storage
   assign wr_entry.source = source_ff;
   assign wr_entry.number = number_ff;
   assign wr_entry.expiry = expiry_ff;
   assign rd_entry        = rdt_pkg::rdt_entry_type'(rd_bits);

   rdt_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(idx_ff),
      .wr_data(wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(idx_ff),
      .rd_data(rd_bits)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_kind == rdt_pkg::KIND_INSERT) ? rdt_pkg::ST_INSERT
                                                            : rdt_pkg::ST_LOOKUP;
            end
         end
         rdt_pkg::ST_INSERT: begin
            if (!used_ff[idx_ff] || last_idx) begin
               state_in = rdt_pkg::ST_FINISH;
            end
         end
         rdt_pkg::ST_LOOKUP: begin
            if (last_idx) begin
               state_in = rdt_pkg::ST_DRAIN;
            end
         end
         rdt_pkg::ST_DRAIN: begin
            state_in = rdt_pkg::ST_FINISH;
         end
         rdt_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = rdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdt_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      used_in       = used_ff;
      idx_in        = idx_ff;
      eval_valid_in = 1'b0;
      hit_in        = hit_ff;
      status_in     = status_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      case (state_ff)
         rdt_pkg::ST_IDLE: begin
            if (req_accept) begin
               idx_in    = '0;
               hit_in    = 1'b0;
               status_in = rdt_pkg::STATUS_DONE;
            end
         end
         rdt_pkg::ST_INSERT: begin
            // first free slot takes the entry
            if (!used_ff[idx_ff]) begin
               ram_wr_en       = 1'b1;
               used_in[idx_ff] = 1'b1;
            end else if (last_idx) begin
               status_in = rdt_pkg::STATUS_FULL;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         rdt_pkg::ST_LOOKUP: begin
            ram_rd_en     = 1'b1;
            eval_valid_in = 1'b1;
            if (!last_idx) begin
               idx_in = idx_ff + IW'(1);
            end
         end
         default: begin
         end
      endcase

      // slot read last cycle: purge if stale, else test for a match
      if (eval_valid_ff && used_ff[eval_idx_ff]) begin
         if (now_ff > rd_entry.expiry) begin
            used_in[eval_idx_ff] = 1'b0;
         end else if (rd_entry.source == source_ff && rd_entry.number == number_ff) begin
            hit_in = 1'b1;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rdt_pkg::ST_IDLE;
         used_ff       <= '0;
         eval_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         eval_valid_ff <= eval_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      eval_idx_ff <= idx_ff;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      if (req_accept) begin
         kind_ff   <= req_kind;
         source_ff <= req_source_address;
         number_ff <= req_broadcast_number;
         expiry_ff <= req_expiry_time;
         now_ff    <= req_now_time;
      end
      if (rsp_load) begin
         rsp_hit_ff    <= hit_ff & (kind_ff == rdt_pkg::KIND_LOOKUP);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;

   // checks
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != rdt_pkg::ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      eval_valid_ff |-> (state_ff == rdt_pkg::ST_LOOKUP || state_ff == rdt_pkg::ST_DRAIN))
      else $error("slot evaluation outside lookup scan");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_ff == rdt_pkg::STATUS_FULL) |-> (&used_ff))
      else $error("full status reported with a free slot");

   a_write_only_insert: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == rdt_pkg::ST_INSERT && !used_ff[idx_ff]))
      else $error("entry write outside insert into a free slot");

endmodule

FILE: sv/rdt_ram.sv
module rdt_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
